// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the escape-time block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg
// Types, constants and helpers of the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

   // Fixed-point and field widths
   localparam int COORD_BITS     = 32;
   localparam int FRAC_BITS      = 28;
   localparam int PIXEL_BITS     = 12;
   localparam int DIM_BITS       = 13;
   localparam int ITER_BITS      = 11;
   localparam int ZOOM_BITS      = 31;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int MAX_ITER_LIMIT = 1024;

   // Signed span * unsigned pixel, exact
   localparam int PROD_BITS      = COORD_BITS + PIXEL_BITS + 1;
   localparam int WIDE_BITS      = 2 * COORD_BITS;

   // Shared divider: numerator is a coordinate magnitude shifted up by the fraction
   localparam int DIV_NUM_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIV_STEP_BITS  = $clog2(DIV_NUM_BITS);

   // Point queue between front and back
   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // |z|^2 escape bound: 4.0 in Q8.56
   localparam logic [WIDE_BITS:0] ESCAPE_BOUND = (WIDE_BITS+1)'(4) << (2 * FRAC_BITS);

   typedef struct packed {
      coord_type cx;
      coord_type cy;
   } point_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  image_width;
      logic [DIM_BITS-1:0]  image_height;
      logic [ITER_BITS-1:0] max_iterations;
      logic [ZOOM_BITS-1:0] zoom;
      coord_type            scale_x;
      coord_type            scale_y;
      coord_type            offset_x;
      coord_type            offset_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_width:    DIM_BITS'(640),
      image_height:   DIM_BITS'(480),
      max_iterations: ITER_BITS'(256),
      zoom:           ZOOM_BITS'(32'h1000_0000),
      scale_x:        32'sh3000_0000,
      scale_y:        32'sh2000_0000,
      offset_x:       32'shE000_0000,
      offset_y:       32'shF000_0000
   };

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_MAX_ITERATIONS = 3'd2,
      CSR_ZOOM           = 3'd3,
      CSR_SCALE_X        = 3'd4,
      CSR_SCALE_Y        = 3'd5,
      CSR_OFFSET_X       = 3'd6,
      CSR_OFFSET_Y       = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_PROD,
      FR_START1,
      FR_DIV1,
      FR_START2,
      FR_DIV2,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_UPD,
      BK_DONE
   } back_state_type;

   // Saturate a wide signed value to Q4.28
   function automatic coord_type sat_coord(input logic signed [WIDE_BITS-1:0] v);
      logic fits;
      fits = (v[WIDE_BITS-1:COORD_BITS-1] == '0) || (v[WIDE_BITS-1:COORD_BITS-1] == '1);
      if (fits) begin
         return v[COORD_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

// ===== rtl/mbet_div.sv =====
// ----------------------------------------------------------------------------
// mbet_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbet_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mbet_pkg::DIV_NUM_BITS-1:0]  num,
   input  logic [mbet_pkg::ZOOM_BITS-1:0]     den,
   output logic                               done,
   output logic [mbet_pkg::DIV_NUM_BITS-1:0]  quot
);
   import mbet_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [ZOOM_BITS-1:0]     rem_ff, rem_in;
   logic [ZOOM_BITS-1:0]     den_ff, den_in;
   logic [DIV_NUM_BITS-1:0]  quo_ff, quo_in;
   logic [ZOOM_BITS:0]       trial;
   logic [ZOOM_BITS:0]       diff;

   // One shift-subtract step; quo_ff shifts numerator out and quotient in
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[ZOOM_BITS-1:0];
            quo_in = {quo_ff[DIV_NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[ZOOM_BITS-1:0];
            quo_in = {quo_ff[DIV_NUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(DIV_NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

   // The front must never restart a division in flight
   `ASSERT_IMPLIES(a_no_start_busy, clock, reset, start, !busy_ff, "divider restarted while busy")

endmodule

// ===== rtl/mbet_fifo.sv =====
// ----------------------------------------------------------------------------
// mbet_fifo
// Short point queue between the mapping front and the iteration back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbet_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mbet_pkg::point_type push_data,
   output logic                full,
   input  logic                pop,
   output mbet_pkg::point_type pop_data,
   output logic                empty
);
   import mbet_pkg::*;

   point_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);

   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `ASSERT_NEXT(a_fill_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue fill lost a push")

endmodule

// ===== rtl/mbet_front.sv =====
// ----------------------------------------------------------------------------
// mbet_front
// Accepts a pixel and maps it to the point c through two divisions per axis.
// ----------------------------------------------------------------------------
module mbet_front (
   input  logic                             clock,
   input  logic                             reset,
   input  mbet_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mbet_pkg::PIXEL_BITS-1:0]  req_pixel_x,
   input  logic [mbet_pkg::PIXEL_BITS-1:0]  req_pixel_y,
   output logic                             push,
   output mbet_pkg::point_type              push_data,
   input  logic                             full
);
   import mbet_pkg::*;

   front_state_type                state_ff, state_in;
   logic                           axis_ff, axis_in;
   logic [PIXEL_BITS-1:0]          px_ff, px_in;
   logic [PIXEL_BITS-1:0]          py_ff, py_in;
   logic signed [PROD_BITS-1:0]    prod_ff, prod_in;
   coord_type                      s_ff, s_in;
   coord_type                      cx_ff, cx_in;
   coord_type                      cy_ff, cy_in;

   coord_type                      span;
   coord_type                      off;
   logic [DIM_BITS-1:0]            dim;
   logic [PIXEL_BITS-1:0]          pix;
   logic signed [PIXEL_BITS:0]     pix_s;
   logic [PROD_BITS-1:0]           prod_abs;
   logic signed [PROD_BITS-1:0]    t_val;
   logic [COORD_BITS-1:0]          s_mag;
   logic signed [WIDE_BITS-1:0]    q_wide;
   coord_type                      coord;

   logic                           div_start;
   logic [DIV_NUM_BITS-1:0]        div_num;
   logic [ZOOM_BITS-1:0]           div_den;
   logic                           div_done;
   logic [DIV_NUM_BITS-1:0]        div_quot;

   mbet_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Per-axis operand selection and datapath
   always_comb begin
      span     = axis_ff ? cfg.scale_y      : cfg.scale_x;
      off      = axis_ff ? cfg.offset_y     : cfg.offset_x;
      dim      = axis_ff ? cfg.image_height : cfg.image_width;
      pix      = axis_ff ? py_ff            : px_ff;
      pix_s    = $signed({1'b0, pix});
      prod_abs = prod_ff[PROD_BITS-1] ? -prod_ff : prod_ff;
      // quotient of the span term fits the product width
      t_val    = prod_ff[PROD_BITS-1] ? -$signed(div_quot[PROD_BITS-1:0])
                                      :  $signed(div_quot[PROD_BITS-1:0]);
      s_mag    = s_ff[COORD_BITS-1] ? -s_ff : s_ff;
      q_wide   = s_ff[COORD_BITS-1] ? -$signed(WIDE_BITS'(div_quot))
                                    :  $signed(WIDE_BITS'(div_quot));
      coord    = sat_coord(q_wide);
   end

   // Divider requests: span term, then zoom division
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = ZOOM_BITS'(1);
      if (state_ff == FR_START1) begin
         div_start = 1'b1;
         // zero dimension leaves only the offset
         if (dim != '0) begin
            div_num = DIV_NUM_BITS'(prod_abs);
            div_den = ZOOM_BITS'(dim);
         end
      end else if (state_ff == FR_START2) begin
         div_start = 1'b1;
         div_num   = {s_mag, {FRAC_BITS{1'b0}}};
         // zero zoom acts as the smallest step
         if (cfg.zoom != '0) begin
            div_den = cfg.zoom;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      prod_in   = prod_ff;
      s_in      = s_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               axis_in  = 1'b0;
               state_in = FR_PROD;
            end
         end
         FR_PROD: begin
            prod_in  = PROD_BITS'(span) * PROD_BITS'(pix_s);
            state_in = FR_START1;
         end
         FR_START1: begin
            state_in = FR_DIV1;
         end
         FR_DIV1: begin
            if (div_done) begin
               s_in     = sat_coord(WIDE_BITS'(t_val) + WIDE_BITS'(off));
               state_in = FR_START2;
            end
         end
         FR_START2: begin
            state_in = FR_DIV2;
         end
         FR_DIV2: begin
            if (div_done) begin
               if (axis_ff) begin
                  cy_in    = coord;
                  state_in = FR_PUSH;
               end else begin
                  cx_in    = coord;
                  axis_in  = 1'b1;
                  state_in = FR_PROD;
               end
            end
         end
         FR_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      axis_ff <= axis_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
   end

   assign push_data = '{cx: cx_ff, cy: cy_ff};

endmodule

// ===== rtl/mbet_core.sv =====
// ----------------------------------------------------------------------------
// mbet_core
// Iterates z = z*z + c for one point and returns the escape count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbet_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mbet_pkg::ITER_BITS-1:0]  max_iterations,
   input  logic                            empty,
   input  mbet_pkg::point_type             pop_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mbet_pkg::ITER_BITS-1:0]  rsp_iteration_count
);
   import mbet_pkg::*;

   back_state_type              state_ff, state_in;
   coord_type                   cx_ff, cx_in;
   coord_type                   cy_ff, cy_in;
   coord_type                   x_ff, x_in;
   coord_type                   y_ff, y_in;
   logic signed [WIDE_BITS-1:0] x2_ff, x2_in;
   logic signed [WIDE_BITS-1:0] y2_ff, y2_in;
   logic signed [WIDE_BITS-1:0] xy_ff, xy_in;
   logic [ITER_BITS-1:0]        n_ff, n_in;
   logic [ITER_BITS-1:0]        limit_ff, limit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ITER_BITS-1:0]        count_ff, count_in;

   logic [WIDE_BITS:0]          mag2;
   logic                        escape;
   logic signed [WIDE_BITS-1:0] re_diff;
   coord_type                   x_next;
   coord_type                   y_next;

   // Escape test and next z from registered products
   always_comb begin
      mag2    = {1'b0, x2_ff} + {1'b0, y2_ff};
      escape  = (mag2 >= ESCAPE_BOUND);
      re_diff = x2_ff - y2_ff;
      x_next  = sat_coord((re_diff >>> FRAC_BITS) + WIDE_BITS'(cx_ff));
      // 2*x*y scaled back by the fraction
      y_next  = sat_coord((xy_ff >>> (FRAC_BITS - 1)) + WIDE_BITS'(cy_ff));
   end

   // Iteration sequencer and output register
   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      xy_in        = xy_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cx_in    = pop_data.cx;
               cy_in    = pop_data.cy;
               x_in     = pop_data.cx;
               y_in     = pop_data.cy;
               n_in     = '0;
               limit_in = (max_iterations > ITER_BITS'(MAX_ITER_LIMIT))
                        ? ITER_BITS'(MAX_ITER_LIMIT) : max_iterations;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            x2_in    = WIDE_BITS'(x_ff) * WIDE_BITS'(x_ff);
            y2_in    = WIDE_BITS'(y_ff) * WIDE_BITS'(y_ff);
            xy_in    = WIDE_BITS'(x_ff) * WIDE_BITS'(y_ff);
            state_in = BK_UPD;
         end
         BK_UPD: begin
            if ((n_ff >= limit_ff) || escape) begin
               state_in = BK_DONE;
            end else begin
               x_in     = x_next;
               y_in     = y_next;
               n_in     = n_ff + 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               count_in     = n_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      x2_ff    <= x2_in;
      y2_ff    <= y2_in;
      xy_ff    <= xy_in;
      n_ff     <= n_in;
      limit_ff <= limit_in;
      count_ff <= count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = count_ff;

   `ASSERT_IMPLIES(a_count_in_limit, clock, reset, state_ff == BK_UPD, n_ff <= limit_ff, "iteration count passed the limit")

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Mandelbrot escape-time counter, signed Q4.28 fixed point.
// Pixels enter on req_* (valid/ready) and one iteration count leaves on rsp_*
// (valid/ready) for every pixel, in order. Write the registers through
// csr_we/csr_index/csr_wdata only while the block is idle; the block itself
// does not enforce this. Reset loads a 640x480 view of [-2,1] x [-1,1] with
// a limit of 256 iterations. The front maps a pixel with one shared divider
// (span term, then zoom, per axis), one pixel at a time. The back runs each
// iteration as a product register step, then a test and update step, one
// point at a time. A two-entry point queue sits between them, so throughput
// is set by the slower side. A stalled receiver holds the result in the
// output register; the back then waits, the queue fills, and req_ready, high
// only while the front is idle, stays low while it holds a point it cannot
// hand over. Reset clears all handshakes and empties the queue.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mbet_pkg::PIXEL_BITS-1:0]     req_pixel_x,
   input  logic [mbet_pkg::PIXEL_BITS-1:0]     req_pixel_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mbet_pkg::ITER_BITS-1:0]      rsp_iteration_count,
   input  logic                                csr_we,
   input  logic [mbet_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [mbet_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mbet_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   point_type push_data;
   logic      full;
   logic      pop;
   point_type pop_data;
   logic      empty;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:    cfg_in.image_width    = csr_wdata[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:   cfg_in.image_height   = csr_wdata[DIM_BITS-1:0];
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_wdata[ITER_BITS-1:0];
            CSR_ZOOM:           cfg_in.zoom           = csr_wdata[ZOOM_BITS-1:0];
            CSR_SCALE_X:        cfg_in.scale_x        = csr_wdata[COORD_BITS-1:0];
            CSR_SCALE_Y:        cfg_in.scale_y        = csr_wdata[COORD_BITS-1:0];
            CSR_OFFSET_X:       cfg_in.offset_x       = csr_wdata[COORD_BITS-1:0];
            CSR_OFFSET_Y:       cfg_in.offset_y       = csr_wdata[COORD_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbet_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .push        (push),
      .push_data   (push_data),
      .full        (full)
   );

   mbet_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mbet_core u_core (
      .clock               (clock),
      .reset               (reset),
      .max_iterations      (cfg_ff.max_iterations),
      .empty               (empty),
      .pop_data            (pop_data),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape-time counter testbench
// Sends pixels through the request channel under several register settings
// and compares each returned iteration count with a fixed-point prediction
// of the pixel mapping and the z = z*z + c iteration, in order of arrival.
// ----------------------------------------------------------------------------
module tb;
   import mbet_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 5;
   localparam int HOLD_CYCLES     = 3000;
   localparam int WATCHDOG_CYCLES = 40000;
   localparam int TAIL_CYCLES     = 2500;
   localparam int VIEWS_PER_MODE  = 4;
   localparam int ITEMS_PER_VIEW  = 46;
   localparam int REPORT_LIMIT    = 10;
   localparam int COUNT_CEILING   = 1024;
   localparam int FRAC            = 28;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;
   // 4.0 in the Q8.56 square domain
   localparam longint unsigned ESCAPE_Q8_56 = 64'd4 << 56;

   typedef struct packed {
      logic [DIM_BITS-1:0]   width;
      logic [DIM_BITS-1:0]   height;
      logic [ITER_BITS-1:0]  iter_limit;
      logic [ZOOM_BITS-1:0]  zoom;
      logic signed [31:0]    scale_x;
      logic signed [31:0]    scale_y;
      logic signed [31:0]    offset_x;
      logic signed [31:0]    offset_y;
   } view_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
      logic [ITER_BITS-1:0]  count;
   } pixel_count_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIXEL_BITS-1:0]    req_pixel_x = '0;
   logic [PIXEL_BITS-1:0]    req_pixel_y = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ITER_BITS-1:0]     rsp_iteration_count;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   view_type        active_view;
   pixel_count_type pending_counts[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int views_applied = 0;
   int counts_checked = 0;
   int count_min = 2047;
   int count_max = 0;
   int quiet_cycles = 0;
   int stall_run = 0;
   int longest_stall = 0;

   mandelbrot_escape_time dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic longint clamp_q(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // pixel -> Q4.28 coordinate: (span*pix/dim + off) / zoom, both steps saturated
   function automatic longint map_axis(input longint pix, input longint span,
                                       input longint dim, input longint off,
                                       input longint unsigned zm);
      longint          term;
      longint          sum;
      longint unsigned mag;
      longint unsigned quo;
      longint unsigned step;
      term = 0;
      if (dim != 0) term = (span * pix) / dim;
      sum  = clamp_q(term + off);
      mag  = (sum < 0) ? -sum : sum;
      // zero zoom behaves as the smallest step
      step = (zm == 0) ? 64'd1 : zm;
      quo  = (mag << FRAC) / step;
      if (sum < 0) return clamp_q(-$signed(quo));
      return clamp_q($signed(quo));
   endfunction

   function automatic logic [ITER_BITS-1:0] escape_count(input logic [PIXEL_BITS-1:0] px,
                                                        input logic [PIXEL_BITS-1:0] py,
                                                        input view_type v);
      longint cx;
      longint cy;
      longint x;
      longint y;
      longint x_sq;
      longint y_sq;
      longint xy;
      int     limit;
      int     n;
      cx = map_axis(64'(px), longint'($signed(v.scale_x)), 64'(v.width),
                    longint'($signed(v.offset_x)), 64'(v.zoom));
      cy = map_axis(64'(py), longint'($signed(v.scale_y)), 64'(v.height),
                    longint'($signed(v.offset_y)), 64'(v.zoom));
      limit = (v.iter_limit > COUNT_CEILING) ? COUNT_CEILING : int'(v.iter_limit);
      // iteration starts at z = c
      x = cx;
      y = cy;
      n = 0;
      while (n < limit) begin
         x_sq = x * x;
         y_sq = y * y;
         if ($unsigned(x_sq) + $unsigned(y_sq) >= ESCAPE_Q8_56) break;
         xy = x * y;
         x  = clamp_q(((x_sq - y_sq) >>> FRAC) + cx);
         y  = clamp_q(((2 * xy) >>> FRAC) + cy);
         n++;
      end
      return ITER_BITS'(n);
   endfunction

   // ------------------------------------------------------------------------
   // Register settings
   // ------------------------------------------------------------------------

   function automatic view_type reset_view();
      view_type v;
      v.width      = 13'd640;
      v.height     = 13'd480;
      v.iter_limit = 11'd256;
      v.zoom       = 31'h1000_0000;
      v.scale_x    = 32'sh3000_0000;
      v.scale_y    = 32'sh2000_0000;
      v.offset_x   = -32'sh2000_0000;
      v.offset_y   = -32'sh1000_0000;
      return v;
   endfunction

   function automatic logic [DIM_BITS-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return 13'd1;
         1:       return 13'd4096;
         default: return 13'($urandom_range(16, 4096));
      endcase
   endfunction

   // viewport settings land near the set; wild ones use any register value
   function automatic view_type random_view(input bit wild);
      view_type v;
      if (wild) begin
         v.width      = 13'($urandom());
         v.height     = 13'($urandom());
         v.iter_limit = 11'($urandom());
         v.zoom       = 31'($urandom());
         v.scale_x    = $urandom();
         v.scale_y    = $urandom();
         v.offset_x   = $urandom();
         v.offset_y   = $urandom();
      end else begin
         v.width      = random_dim();
         v.height     = random_dim();
         v.iter_limit = 11'($urandom_range(1, 100));
         v.zoom       = 31'($urandom_range(32'h0800_0000, 32'h2000_0000));
         v.scale_x    = $urandom_range(32'h0400_0000, 32'h4000_0000);
         v.scale_y    = $urandom_range(32'h0400_0000, 32'h4000_0000);
         if ($urandom_range(0, 7) == 0) v.scale_x = -v.scale_x;
         if ($urandom_range(0, 7) == 0) v.scale_y = -v.scale_y;
         v.offset_x   = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
         v.offset_y   = $urandom_range(0, 32'h2000_0000) - 32'h1800_0000;
      end
      return v;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // unused upper bits of the narrow registers carry random junk
   task automatic apply_view(input view_type v);
      logic [31:0] junk;
      junk = $urandom();
      write_reg(CSR_IMAGE_WIDTH,    {junk[31:13], v.width});
      write_reg(CSR_IMAGE_HEIGHT,   {junk[18:0], v.height});
      write_reg(CSR_MAX_ITERATIONS, {junk[20:0], v.iter_limit});
      write_reg(CSR_ZOOM,           {junk[31], v.zoom});
      write_reg(CSR_SCALE_X,        v.scale_x);
      write_reg(CSR_SCALE_Y,        v.scale_y);
      write_reg(CSR_OFFSET_X,       v.offset_x);
      write_reg(CSR_OFFSET_Y,       v.offset_y);
      csr_we <= 1'b0;
      active_view = v;
      views_applied++;
   endtask

   // ------------------------------------------------------------------------
   // Pixel sender and result side
   // ------------------------------------------------------------------------

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] px,
                             input logic [PIXEL_BITS-1:0] py);
      pixel_count_type entry;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entry.pixel_x = px;
      entry.pixel_y = py;
      entry.count   = escape_count(px, py, active_view);
      pending_counts.push_back(entry);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   // random ready, or a long hold-off when the test asks for one
   initial begin : result_receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // compare each returned count with the oldest prediction
   always @(posedge clock) begin : result_check
      pixel_count_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected count %0d with no pixel outstanding",
                        rsp_iteration_count);
         end else begin
            head = pending_counts.pop_front();
            counts_checked++;
            if (int'(rsp_iteration_count) < count_min)
               count_min = int'(rsp_iteration_count);
            if (int'(rsp_iteration_count) > count_max)
               count_max = int'(rsp_iteration_count);
            if (rsp_iteration_count !== head.count) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("pixel (%0d,%0d): count expected %0d, got %0d",
                           head.pixel_x, head.pixel_y, head.count, rsp_iteration_count);
            end
         end
      end
   end

   // watchdog on cycles with no item moving; also tracks input stalls
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (req_valid && !req_ready) stall_run <= stall_run + 1;
      else stall_run <= 0;
      if (stall_run > longest_stall) longest_stall <= stall_run;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("timeout: nothing moved for %0d cycles, %0d counts outstanding",
                  quiet_cycles, pending_counts.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // reset view, no register writes: corners and two points inside the set
   task automatic test_reset_view();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd400, 12'd240);
      send_pixel(12'd320, 12'd240);
      req_valid <= 1'b0;
   endtask

   task automatic run_corners(input view_type v);
      wait_drained();
      apply_view(v);
      send_pixel('0, '0);
      send_pixel('1, '1);
      req_valid <= 1'b0;
   endtask

   task automatic test_special_cases();
      view_type v;
      // zero width and height: every pixel maps to offset / zoom
      v = reset_view();
      v.width      = '0;
      v.height     = '0;
      v.iter_limit = 11'd50;
      v.offset_x   = -32'sh0800_0000;
      v.offset_y   = 32'sh0400_0000;
      run_corners(v);
      // zero zoom acts as one raw step, so tiny offsets become whole units
      v = reset_view();
      v.zoom       = '0;
      v.iter_limit = 11'd50;
      v.offset_x   = 32'sd3;
      v.offset_y   = -32'sd1;
      run_corners(v);
      // limit zero
      v = reset_view();
      v.iter_limit = '0;
      run_corners(v);
      // c = 0 never escapes: runs to the top limit, and to the clamp above it
      v = reset_view();
      v.scale_x    = '0;
      v.scale_y    = '0;
      v.offset_x   = '0;
      v.offset_y   = '0;
      v.iter_limit = 11'd1024;
      run_corners(v);
      v.iter_limit = 11'd2047;
      run_corners(v);
      // register extremes, largest zoom
      v.width      = 13'd1;
      v.height     = 13'd4096;
      v.iter_limit = 11'd1024;
      v.zoom       = 31'h7FFF_FFFF;
      v.scale_x    = 32'sh8000_0000;
      v.scale_y    = 32'sh7FFF_FFFF;
      v.offset_x   = 32'sh7FFF_FFFF;
      v.offset_y   = 32'sh8000_0000;
      run_corners(v);
      // opposite extremes, smallest zoom: coordinates saturate
      v.width      = 13'd4096;
      v.height     = 13'd1;
      v.zoom       = 31'd1;
      v.scale_x    = 32'sh7FFF_FFFF;
      v.scale_y    = 32'sh8000_0000;
      v.offset_x   = 32'sh8000_0000;
      v.offset_y   = 32'sh7FFF_FFFF;
      run_corners(v);
   endtask

   // result side holds off while pixels keep coming, so the input stalls
   task automatic test_output_backpressure();
      view_type v;
      v = reset_view();
      v.iter_limit = 11'd20;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_drained();
      apply_view(v);
      hold_requests++;
      for (int i = 0; i < 10; i++)
         send_pixel(12'($urandom_range(0, 639)), 12'($urandom_range(0, 479)));
      req_valid <= 1'b0;
   endtask

   task automatic test_random_views();
      view_type              v;
      logic [PIXEL_BITS-1:0] px;
      logic [PIXEL_BITS-1:0] py;
      bit                    wild;
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int k = 0; k < VIEWS_PER_MODE; k++) begin
            wild = (k == VIEWS_PER_MODE - 1);
            v = random_view(wild);
            wait_drained();
            apply_view(v);
            for (int i = 0; i < ITEMS_PER_VIEW; i++) begin
               // mostly pixels inside the image, some anywhere in the field
               if (wild || $urandom_range(0, 4) == 0) begin
                  px = 12'($urandom());
                  py = 12'($urandom());
               end else begin
                  px = 12'($urandom_range(0, int'(v.width) - 1));
                  py = 12'($urandom_range(0, int'(v.height) - 1));
               end
               send_pixel(px, py);
            end
            req_valid <= 1'b0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      active_view = reset_view();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 68;
      test_reset_view();
      test_special_cases();
      test_output_backpressure();
      test_random_views();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_counts.size() != 0) begin
         error_count += pending_counts.size();
         $display("%0d predicted counts never arrived", pending_counts.size());
      end
      $display("Ran %0d pixels over %0d register settings: zero sizes, zero zoom, %s%0d-cycle %s",
               pixels_sent, views_applied, "limits 0 to 2047, ", HOLD_CYCLES,
               "result hold-off.");
      $display("Compared %0d counts (from %0d to %0d); longest input stall %0d cycles; %s",
               counts_checked, count_min, count_max, longest_stall,
               $sformatf("%0d errors.", error_count));
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbet_pkg.sv
rtl/mbet_div.sv
rtl/mbet_fifo.sv
rtl/mbet_front.sv
rtl/mbet_core.sv
rtl/mandelbrot_escape_time.sv
tb/sv/tb.sv
